/* rtl/wpsn_pkg.sv */
package wpsn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROP_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int SUM_W    = 48;
  localparam int RATIO_W  = 32;

  // Product of sample and propagator carries 22 fraction bits; times the
  // Q2.14 gain it carries 36, so 28 bits drop to land back on Q7.8.
  localparam int ROUND_SH = 28;

  // Shared multiplier: wide signed operand and narrow signed operand.
  localparam int MUL_A_W = SAMPLE_W + PROP_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SQ_W    = 2 * SAMPLE_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SUM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_QUENCH_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_DIV    = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] psi_re;
    logic signed [SAMPLE_W-1:0] psi_im;
    logic signed [PROP_W-1:0]   prop_re;
    logic signed [PROP_W-1:0]   prop_im;
    logic                       frame_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] new_re;
    logic signed [SAMPLE_W-1:0] new_im;
    logic                       result_last;
    logic [RATIO_W-1:0]         norm_ratio;
    logic                       norm_invalid;
  } out_item_t;

endpackage

/* rtl/wpsn_in_if.sv */
interface wpsn_in_if;
  logic                 valid;
  logic                 ready;
  wpsn_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wpsn_out_if.sv */
interface wpsn_out_if;
  logic                 valid;
  logic                 ready;
  wpsn_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wave_position_step_with_norm.sv */
// Position step of a split-step propagator with a frame energy check. Each
// item brings one complex Q7.8 wave sample and its Q1.14 propagator sample;
// a propagator of exactly zero is a wall and erases the sample. Otherwise the
// complex product is scaled by quench_gain (Q2.14), rounded half up and
// saturated, and its squared magnitude is added to a 48-bit saturating
// energy sum. The item flagged frame_last also returns the energy over
// norm_divisor as unsigned Q16.16 (saturated; all ones with norm_invalid set
// when the divisor is zero) and clears the sum. All arithmetic runs through
// one 33x17 signed multiplier under a nine-step sequencer, and a frame-closing
// item with a nonzero divisor and an unsaturated ratio goes on through a
// one-bit-per-cycle restoring divider. The input is not ready while an item
// is at work; the result sits in an output register, so a waiting result does
// not block the next item until that item is finished too. Write the
// configuration only while the block is idle.
module wave_position_step_with_norm (
  input  logic                                clk,
  input  logic                                rst_n,
  wpsn_in_if.sink                             in_ch,
  wpsn_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [wpsn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpsn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SW = wpsn_pkg::SAMPLE_W;
  localparam int PW = wpsn_pkg::PROP_W;
  localparam int GW = wpsn_pkg::GAIN_W;
  localparam int UW = wpsn_pkg::SUM_W;
  localparam int RW = wpsn_pkg::RATIO_W;
  localparam int AW = wpsn_pkg::MUL_A_W;
  localparam int BW = wpsn_pkg::MUL_B_W;
  localparam int QW = wpsn_pkg::PROD_W;
  localparam int XW = wpsn_pkg::SQ_W;
  localparam int RS = wpsn_pkg::ROUND_SH;

  localparam logic [4:0] DIV_LAST  = 5'd31;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [GW-1:0] gain_r;
  logic [UW-1:0] ndiv_r;

  // Item registers
  logic signed [SW-1:0] a_r, b_r;
  logic signed [PW-1:0] c_r, d_r;
  logic                 last_r, wall_r;

  // Sequencer and datapath registers
  logic [3:0]           step_r, step_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] pre_r, pre_nxt;
  logic signed [AW-1:0] pim_r, pim_nxt;
  logic signed [SW-1:0] nre_r, nre_nxt;
  logic signed [SW-1:0] nim_r, nim_nxt;
  logic [XW-1:0]        en_r, en_nxt;
  logic [UW-1:0]        sum_r, sum_nxt;

  // Divider registers
  logic [UW-1:0]  rem_r, rem_nxt;
  logic [RW-1:0]  quot_r, quot_nxt;
  logic [RW-1:0]  nlow_r, nlow_nxt;
  logic [4:0]     dcnt_r, dcnt_nxt;
  logic [RW-1:0]  ratio_r, ratio_nxt;
  logic           inval_r, inval_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  wpsn_pkg::out_item_t out_data_r, out_data_nxt;

  // Shared multiplier
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [QW-1:0] prod;
  logic signed [QW-1:0] rnd;
  logic signed [SW-1:0] scaled;
  logic [UW:0]          sum_add;
  logic [UW+1:0]        dif;
  logic                 in_acc;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;

  // Pick the multiplier operands for the current step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      4'd0: begin mul_a = AW'(a_r);   mul_b = BW'(c_r); end
      4'd1: begin mul_a = AW'(b_r);   mul_b = BW'(d_r); end
      4'd2: begin mul_a = AW'(b_r);   mul_b = BW'(c_r); end
      4'd3: begin mul_a = AW'(a_r);   mul_b = BW'(d_r); end
      4'd4: begin mul_a = pre_r;      mul_b = $signed({1'b0, gain_r}); end
      4'd5: begin mul_a = pim_r;      mul_b = $signed({1'b0, gain_r}); end
      4'd6: begin mul_a = AW'(nre_r); mul_b = BW'(nre_r); end
      4'd7: begin mul_a = AW'(nim_r); mul_b = BW'(nim_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Round half up to Q7.8, then saturate to the sample range.
  assign rnd = prod + QW'(64'sd1 <<< (RS - 1));

  always_comb begin
    if ((&rnd[QW-1:RS+SW-1]) || !(|rnd[QW-1:RS+SW-1])) begin
      scaled = rnd[RS+SW-1:RS];
    end else if (rnd[QW-1]) begin
      scaled = {1'b1, {(SW-1){1'b0}}};
    end else begin
      scaled = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign sum_add = {1'b0, sum_r} + (UW+1)'(en_r);
  assign dif     = {1'b0, rem_r, nlow_r[RW-1]} - {2'b00, ndiv_r};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    pre_nxt       = pre_r;
    pim_nxt       = pim_r;
    nre_nxt       = nre_r;
    nim_nxt       = nim_r;
    en_nxt        = en_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    nlow_nxt      = nlow_r;
    dcnt_nxt      = dcnt_r;
    ratio_nxt     = ratio_r;
    inval_nxt     = inval_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          step_nxt  = '0;
          state_nxt = ST_MAC;
        end
      end

      ST_MAC: begin
        step_nxt = step_r + 4'd1;
        unique case (step_r)
          4'd0: acc_nxt = prod[AW-1:0];
          4'd1: pre_nxt = acc_r - prod[AW-1:0];
          4'd2: acc_nxt = prod[AW-1:0];
          4'd3: pim_nxt = acc_r + prod[AW-1:0];
          4'd4: nre_nxt = wall_r ? '0 : scaled;
          4'd5: nim_nxt = wall_r ? '0 : scaled;
          4'd6: en_nxt  = prod[XW-1:0];
          4'd7: en_nxt  = en_r + prod[XW-1:0];
          default: begin
            // Saturating add into the frame energy.
            sum_nxt   = sum_add[UW] ? '1 : sum_add[UW-1:0];
            state_nxt = ST_CHECK;
          end
        endcase
      end

      ST_CHECK: begin
        priority if (!last_r) begin
          ratio_nxt = '0;
          inval_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else if (ndiv_r == '0) begin
          ratio_nxt = '1;
          inval_nxt = 1'b1;
          sum_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (UW'(sum_r[UW-1:RW/2]) >= ndiv_r) begin
          // Quotient would need more than 32 bits.
          ratio_nxt = '1;
          inval_nxt = 1'b0;
          sum_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = UW'(sum_r[UW-1:RW/2]);
          nlow_nxt  = {sum_r[RW/2-1:0], {(RW/2){1'b0}}};
          quot_nxt  = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        // One restoring step: shift in a dividend bit, subtract if it fits.
        if (dif[UW+1]) begin
          rem_nxt = {rem_r[UW-2:0], nlow_r[RW-1]};
        end else begin
          rem_nxt = dif[UW-1:0];
        end
        quot_nxt = {quot_r[RW-2:0], ~dif[UW+1]};
        nlow_nxt = {nlow_r[RW-2:0], 1'b0};
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == DIV_LAST) begin
          ratio_nxt = {quot_r[RW-2:0], ~dif[UW+1]};
          inval_nxt = 1'b0;
          sum_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.new_re       = nre_r;
          out_data_nxt.new_im       = nim_r;
          out_data_nxt.result_last  = last_r;
          out_data_nxt.norm_ratio   = ratio_r;
          out_data_nxt.norm_invalid = inval_r;
          state_nxt                 = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      dcnt_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      gain_r      <= wpsn_pkg::GAIN_RESET;
      ndiv_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      dcnt_r      <= dcnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          wpsn_pkg::CFG_QUENCH_GAIN: gain_r <= cfg_wdata[GW-1:0];
          wpsn_pkg::CFG_NORM_DIV:    ndiv_r <= cfg_wdata[UW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r    <= in_ch.data.psi_re;
      b_r    <= in_ch.data.psi_im;
      c_r    <= in_ch.data.prop_re;
      d_r    <= in_ch.data.prop_im;
      last_r <= in_ch.data.frame_last;
      wall_r <= (in_ch.data.prop_re == '0) && (in_ch.data.prop_im == '0);
    end
    acc_r      <= acc_nxt;
    pre_r      <= pre_nxt;
    pim_r      <= pim_nxt;
    nre_r      <= nre_nxt;
    nim_r      <= nim_nxt;
    en_r       <= en_nxt;
    rem_r      <= rem_nxt;
    quot_r     <= quot_nxt;
    nlow_r     <= nlow_nxt;
    ratio_r    <= ratio_nxt;
    inval_r    <= inval_nxt;
    out_data_r <= out_data_nxt;
  end

  // An accepted item drops ready; the design keeps it low for the whole of the item's work.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input ready right after an accepted item");

  // Ratio and flag are zero on results that do not close a frame.
  a_ratio_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.result_last) |->
      (out_data_r.norm_ratio == '0 && !out_data_r.norm_invalid))
    else $error("ratio on a result that does not close the frame");

  // A zero divisor reports a saturated ratio.
  a_invalid_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.norm_invalid) |->
      (out_data_r.result_last && (&out_data_r.norm_ratio)))
    else $error("invalid ratio not saturated");

  // A wall item erases the sample.
  a_wall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && wall_r) |-> (nre_r == '0 && nim_r == '0 && en_r == '0))
    else $error("wall sample not erased");

endmodule

/* bench/tb_wave_position_step_with_norm.sv */
`timescale 1ns / 1ps

module tb_wave_position_step_with_norm;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int RESET_CYCLES  = 12;
  // Covers the sequencer plus the divider, with margin.
  localparam int DRAIN_CYCLES  = 64;
  localparam int MAX_IDLE      = 17;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 40;

  localparam int SAMPLE_W   = wpsn_pkg::SAMPLE_W;
  localparam int PROP_W     = wpsn_pkg::PROP_W;
  localparam int GAIN_W     = wpsn_pkg::GAIN_W;
  localparam int RATIO_W    = wpsn_pkg::RATIO_W;
  localparam int CFG_IDX_W  = wpsn_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = wpsn_pkg::CFG_DATA_W;

  localparam logic [63:0]           SUM_MAX   = (64'd1 << wpsn_pkg::SUM_W) - 1;
  localparam logic [RATIO_W-1:0]    RATIO_SAT = '1;
  localparam logic [CFG_DATA_W-1:0] DIV_MAX   = '1;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table: either a sample to send (optionally with
  // a hand-written expectation) or a register write.
  typedef struct {
    row_kind_t             kind;
    wpsn_pkg::in_item_t    item;
    bit                    typed;
    wpsn_pkg::out_item_t   want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wpsn_in_if  in_ch();
  wpsn_out_if out_ch();

  wave_position_step_with_norm u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the registers and the energy accumulator.
  longint      gain_q214;
  logic [63:0] norm_div_ref;
  logic [63:0] energy_acc;

  wpsn_pkg::out_item_t expected_samples[$];
  stim_row_t           directed_rows[$];

  int cycle_count    = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int frames_closed  = 0;
  int reg_writes     = 0;

  // Shared between the sender and the receiver processes.
  bit no_idle       = 1'b0;
  bit long_hold_req = 1'b0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_sample(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Product carries 22 fraction bits, gain adds 14; round half up back to 8.
  function automatic longint scale_round(longint p);
    return (p * gain_q214 + (longint'(1) <<< (wpsn_pkg::ROUND_SH - 1)))
           >>> wpsn_pkg::ROUND_SH;
  endfunction

  // Advance the energy accumulator by one sample and return the new sample.
  function automatic wpsn_pkg::out_item_t propagate_sample(wpsn_pkg::in_item_t smp);
    longint              a;
    longint              b;
    longint              c;
    longint              d;
    longint              nr;
    longint              ni;
    logic [63:0]         e;
    logic [63:0]         q;
    wpsn_pkg::out_item_t res;
    a  = $signed(smp.psi_re);
    b  = $signed(smp.psi_im);
    c  = $signed(smp.prop_re);
    d  = $signed(smp.prop_im);
    nr = 0;
    ni = 0;
    // A propagator of exactly zero is a wall: the sample stays erased.
    if (c != 0 || d != 0) begin
      nr = clamp_sample(scale_round(a * c - b * d));
      ni = clamp_sample(scale_round(b * c + a * d));
    end
    e = 64'(nr * nr + ni * ni);
    if (e > SUM_MAX - energy_acc) begin
      energy_acc = SUM_MAX;
    end else begin
      energy_acc = energy_acc + e;
    end
    res             = '0;
    res.new_re      = SAMPLE_W'(nr);
    res.new_im      = SAMPLE_W'(ni);
    res.result_last = smp.frame_last;
    if (smp.frame_last) begin
      if (norm_div_ref == 0) begin
        res.norm_invalid = 1'b1;
        res.norm_ratio   = RATIO_SAT;
      end else begin
        q = (energy_acc << 16) / norm_div_ref;
        res.norm_ratio = (q > 64'(RATIO_SAT)) ? RATIO_SAT : RATIO_W'(q);
      end
      energy_acc = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t item_row(int re, int im, int pr, int pm, bit last);
    stim_row_t row;
    row.kind             = ROW_ITEM;
    row.item.psi_re      = SAMPLE_W'(re);
    row.item.psi_im      = SAMPLE_W'(im);
    row.item.prop_re     = PROP_W'(pr);
    row.item.prop_im     = PROP_W'(pm);
    row.item.frame_last  = last;
    row.typed            = 1'b0;
    row.want             = '0;
    row.reg_idx          = '0;
    row.reg_val          = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(int re, int im, int pr, int pm, bit last,
                                          int nre, int nim,
                                          logic [RATIO_W-1:0] ratio, bit inv);
    stim_row_t row;
    row                   = item_row(re, im, pr, pm, last);
    row.typed             = 1'b1;
    row.want.new_re       = SAMPLE_W'(nre);
    row.want.new_im       = SAMPLE_W'(nim);
    row.want.result_last  = last;
    row.want.norm_ratio   = ratio;
    row.want.norm_invalid = inv;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row         = item_row(0, 0, 0, 0, 1'b0);
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap, hold it until accepted, then predict.
  task automatic send_sample(input wpsn_pkg::in_item_t smp, input bit use_typed,
                             input wpsn_pkg::out_item_t typed_want);
    int                  gap;
    wpsn_pkg::out_item_t predicted;
    gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
    // Drop valid only when a gap is due; back-to-back items keep it high.
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= smp;
    do @(posedge clk); while (!in_ch.ready);
    predicted = propagate_sample(smp);
    expected_samples.push_back(use_typed ? typed_want : predicted);
    items_sent++;
    if (smp.frame_last) frames_closed++;
  endtask

  // Stop offering, let every expected item drain and the sequencer settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx,
                           input logic [CFG_DATA_W-1:0] reg_val);
    cfg_we    <= 1'b1;
    cfg_index <= reg_idx;
    cfg_wdata <= reg_val;
    @(posedge clk);
    // Drop cfg_we again before returning, so back-to-back writes never double-drive cfg_we.
    cfg_we <= 1'b0;
    @(posedge clk);
    if (reg_idx == wpsn_pkg::CFG_QUENCH_GAIN) begin
      gain_q214 = longint'(reg_val[GAIN_W-1:0]);
    end else if (reg_idx == wpsn_pkg::CFG_NORM_DIV) begin
      norm_div_ref = 64'(reg_val);
    end
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: compare every item against the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic check_result(input wpsn_pkg::out_item_t got);
    wpsn_pkg::out_item_t want;
    results_seen++;
    if (expected_samples.size() == 0) begin
      $error("result with no expectation: new_re=%0d new_im=%0d last=%0b",
             got.new_re, got.new_im, got.result_last);
      mismatch_count++;
      return;
    end
    want = expected_samples.pop_front();
    if (got.new_re !== want.new_re) begin
      $error("new_re: expected %0d, actual %0d", want.new_re, got.new_re);
      mismatch_count++;
    end
    if (got.new_im !== want.new_im) begin
      $error("new_im: expected %0d, actual %0d", want.new_im, got.new_im);
      mismatch_count++;
    end
    if (got.result_last !== want.result_last) begin
      $error("result_last: expected %0b, actual %0b", want.result_last, got.result_last);
      mismatch_count++;
    end
    if (got.norm_ratio !== want.norm_ratio) begin
      $error("norm_ratio: expected %0d, actual %0d", want.norm_ratio, got.norm_ratio);
      mismatch_count++;
    end
    if (got.norm_invalid !== want.norm_invalid) begin
      $error("norm_invalid: expected %0b, actual %0b", want.norm_invalid,
             got.norm_invalid);
      mismatch_count++;
    end
  endtask

  // Sample the handshake just after the edge, where the values seen are the
  // ones the block saw. Draw a fresh stall after each item; a long hold
  // request from the sender overrides it so the block backs up.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        check_result(out_ch.data);
        stall_left = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t          row;
    wpsn_pkg::in_item_t smp;
    int                 frame_len;
    int                 amp_shift;
    int                 phase_items;
    int                 gain_pick;
    int                 div_pick;

    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;

    gain_q214    = longint'(wpsn_pkg::GAIN_RESET);
    norm_div_ref = '0;
    energy_acc   = '0;

    // Reset values first: unity gain, zero reference energy.
    // Wall erases even a full-scale sample.
    directed_rows.push_back(typed_row(32767, -32768, 0, 0, 1'b0, 0, 0, '0, 1'b0));
    // Unity propagator passes the sample through.
    directed_rows.push_back(typed_row(256, -512, 16384, 0, 1'b0, 256, -512, '0, 1'b0));
    // Positive and negative saturation of the imaginary part.
    directed_rows.push_back(typed_row(32767, 32767, 16384, 16384, 1'b0,
                                      0, 32767, '0, 1'b0));
    directed_rows.push_back(typed_row(-32768, -32768, 16384, 16384, 1'b0,
                                      0, -32768, '0, 1'b0));
    // Exact halves round up: +0.5 goes to 1, -0.5 goes to 0.
    directed_rows.push_back(typed_row(1, 0, 8192, 0, 1'b0, 1, 0, '0, 1'b0));
    directed_rows.push_back(typed_row(-1, 0, 8192, 0, 1'b0, 0, 0, '0, 1'b0));
    // Zero real part alone is not a wall.
    directed_rows.push_back(typed_row(256, 0, 0, 16384, 1'b0, 0, 256, '0, 1'b0));
    directed_rows.push_back(item_row(32767, -32768, -16384, -16384, 1'b0));
    // Propagator patterns outside the nominal range are used as given.
    directed_rows.push_back(item_row(-32768, 32767, -32768, 32767, 1'b0));
    // Close the frame against a zero reference: flagged, all ones.
    directed_rows.push_back(typed_row(100, 0, 16384, 0, 1'b1, 100, 0, RATIO_SAT, 1'b1));
    // Reference of one: any energy of 1.0 or more saturates the ratio.
    directed_rows.push_back(cfg_row(wpsn_pkg::CFG_NORM_DIV, CFG_DATA_W'(1)));
    directed_rows.push_back(typed_row(256, 0, 16384, 0, 1'b1, 256, 0, RATIO_SAT, 1'b0));
    // Reference equal to one frame of unit energy gives a ratio of 1.0.
    directed_rows.push_back(cfg_row(wpsn_pkg::CFG_NORM_DIV, CFG_DATA_W'(65536)));
    directed_rows.push_back(typed_row(256, 0, 16384, 0, 1'b1, 256, 0,
                                      RATIO_W'(65536), 1'b0));
    // Zero gain kills everything, so the frame ratio is zero.
    directed_rows.push_back(cfg_row(wpsn_pkg::CFG_QUENCH_GAIN, '0));
    directed_rows.push_back(typed_row(32767, 32767, 16384, -16384, 1'b0, 0, 0, '0, 1'b0));
    directed_rows.push_back(typed_row(-32768, 12345, -16384, 16384, 1'b1, 0, 0, '0, 1'b0));
    // Largest gain.
    directed_rows.push_back(cfg_row(wpsn_pkg::CFG_QUENCH_GAIN,
                                    CFG_DATA_W'({GAIN_W{1'b1}})));
    directed_rows.push_back(item_row(256, -256, 16384, 0, 1'b0));
    directed_rows.push_back(item_row(32767, -32768, 16384, 16384, 1'b0));
    directed_rows.push_back(item_row(-1, 1, 1, -1, 1'b0));
    directed_rows.push_back(item_row(300, -40, 12000, -9000, 1'b1));
    // Largest reference energy: tiny ratios.
    directed_rows.push_back(cfg_row(wpsn_pkg::CFG_NORM_DIV, DIV_MAX));
    directed_rows.push_back(item_row(32767, 32767, 16384, 0, 1'b1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_sample(row.item, row.typed, row.want);
      end
    end

    // Random frames under a new register setting per phase. The first
    // phases walk the gain and divisor extremes in turn.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      gain_pick = (phase < 4) ? phase : $urandom_range(3, 0);
      div_pick  = (phase < 5) ? phase : $urandom_range(4, 0);
      case (gain_pick)
        0:       write_reg(wpsn_pkg::CFG_QUENCH_GAIN, '0);
        1:       write_reg(wpsn_pkg::CFG_QUENCH_GAIN, CFG_DATA_W'(wpsn_pkg::GAIN_RESET));
        2:       write_reg(wpsn_pkg::CFG_QUENCH_GAIN, CFG_DATA_W'({GAIN_W{1'b1}}));
        default: write_reg(wpsn_pkg::CFG_QUENCH_GAIN, CFG_DATA_W'($urandom));
      endcase
      case (div_pick)
        0:       write_reg(wpsn_pkg::CFG_NORM_DIV, '0);
        1:       write_reg(wpsn_pkg::CFG_NORM_DIV, CFG_DATA_W'(1));
        2:       write_reg(wpsn_pkg::CFG_NORM_DIV, DIV_MAX);
        3:       write_reg(wpsn_pkg::CFG_NORM_DIV, CFG_DATA_W'({$urandom, $urandom}));
        // Scale the reference near typical frame energies so the ratio
        // lands in range rather than always saturating or vanishing.
        default: write_reg(wpsn_pkg::CFG_NORM_DIV,
                           CFG_DATA_W'({$urandom, $urandom} >> $urandom_range(60, 24)));
      endcase

      // Phase 1, and now and then another phase, runs with no idling on either side.
      no_idle = (phase == 1) || ($urandom_range(5, 0) == 0);
      // Hold the receiver off long enough for the block to back up.
      if (phase == 3) long_hold_req = 1'b1;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // Mostly short frames, now and then a longer one.
        frame_len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20)
                                                 : $urandom_range(12, 1);
        // Half the frames at full scale, the rest shrunk to avoid saturation.
        amp_shift = ($urandom_range(1, 0) == 1) ? 0 : $urandom_range(8, 1);
        for (int k = 0; k < frame_len; k++) begin
          smp.psi_re = $signed(SAMPLE_W'($urandom)) >>> amp_shift;
          smp.psi_im = $signed(SAMPLE_W'($urandom)) >>> amp_shift;
          case ($urandom_range(9, 0))
            0: begin
              smp.prop_re = '0;
              smp.prop_im = '0;
            end
            1: begin
              smp.prop_re = PROP_W'($urandom);
              smp.prop_im = PROP_W'($urandom);
            end
            2: begin
              smp.prop_re = PROP_W'($urandom_range(32768, 0) - 16384);
              smp.prop_im = '0;
            end
            default: begin
              smp.prop_re = PROP_W'($urandom_range(32768, 0) - 16384);
              smp.prop_im = PROP_W'($urandom_range(32768, 0) - 16384);
            end
          endcase
          // Close at the end of the frame, with a stray early close as noise.
          smp.frame_last = (k == frame_len - 1) || ($urandom_range(40, 0) == 0);
          send_sample(smp, 1'b0, '0);
          phase_items++;
          // Pause the sender mid-phase until every expected item is back.
          if (phase == 6 && phase_items == PHASE_ITEMS / 2) begin
            in_ch.valid <= 1'b0;
            while (expected_samples.size() != 0) @(posedge clk);
          end
        end
      end
    end

    wait_idle();
    $display("Checked %0d results for %0d samples in %0d frames over %0d register writes.",
             results_seen, items_sent, frames_closed, reg_writes);
    $display("Walls, rounding halves, saturation, zero reference and back-pressure ran.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
